FILE: hw/rtl/colour_window_math_macros.svh
// Assertion macros used by the checker of the colour window math block.
`ifndef COLOUR_WINDOW_MATH_MACROS_SVH
`define COLOUR_WINDOW_MATH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CWM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("colour_window_math: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("colour_window_math: next-cycle check failed");

`endif

FILE: hw/rtl/cwm_pkg.sv
`timescale 1ns / 1ps
package cwm_pkg;

  localparam int COMP_COUNT  = 3;
  localparam int COMP_WIDTH  = 5;
  localparam int COLOUR_W    = 15;
  localparam int LAYER_COUNT = 6;
  localparam int TDATA_IN_W  = 72;
  localparam int RGB_W       = 24;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam logic [7:0] EDGE_LEFT_OPEN  = 8'd0;
  localparam logic [7:0] EDGE_RIGHT_OPEN = 8'd255;
  localparam logic [4:0] COMP_MAX        = 5'd31;
  // Reciprocal of 15 scaled by 2^15; exact for products up to 255 * 15.
  localparam int RECIP15_SHIFT = 15;
  localparam logic [23:0] RECIP15 = 24'd2185;

  typedef enum logic {
    ACT_PAL_WRITE = 1'b0,
    ACT_COMPOSE   = 1'b1
  } cwm_action_t;

  typedef enum logic [2:0] {
    REG_MATH_SELECT  = 3'd0,
    REG_MATH_ENABLE  = 3'd1,
    REG_FIXED_COLOUR = 3'd2,
    REG_BRIGHTNESS   = 3'd3,
    REG_WIN_ONE      = 3'd4,
    REG_WIN_TWO      = 3'd5,
    REG_WIN_CONTROL  = 3'd6,
    REG_MARGIN       = 3'd7
  } cwm_reg_t;

  typedef enum logic [1:0] {
    WIN_NEVER   = 2'd0,
    WIN_OUTSIDE = 2'd1,
    WIN_INSIDE  = 2'd2,
    WIN_ALWAYS  = 2'd3
  } cwm_win_mode_t;

  typedef enum logic [1:0] {
    COMB_OR   = 2'd0,
    COMB_AND  = 2'd1,
    COMB_XOR  = 2'd2,
    COMB_XNOR = 2'd3
  } cwm_comb_t;

  typedef struct packed {
    logic [7:0]  math_select;
    logic [7:0]  math_enable;
    logic [14:0] fixed_colour;
    logic [3:0]  brightness;
    logic [15:0] win_one;
    logic [15:0] win_two;
    logic [5:0]  win_control;
    logic [7:0]  margin;
  } cwm_cfg_t;

  typedef logic [COMP_COUNT-1:0][COMP_WIDTH-1:0] cwm_comp_t;

  function automatic logic mode_holds(input cwm_win_mode_t mode, input logic in_win);
    logic hit;
    hit = 1'b0;
    unique case (mode)
      WIN_NEVER:   hit = 1'b0;
      WIN_OUTSIDE: hit = !in_win;
      WIN_INSIDE:  hit = in_win;
      WIN_ALWAYS:  hit = 1'b1;
      default:     hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

FILE: hw/rtl/cwm_ram.sv
`timescale 1ns / 1ps
module cwm_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/cwm_window.sv
`timescale 1ns / 1ps
module cwm_window (
  input  cwm_pkg::cwm_cfg_t  cfg,
  input  logic signed [10:0] x_position,
  output logic               in_win
);
  import cwm_pkg::*;

  logic signed [11:0] x_ext;
  logic               hit_one;
  logic               hit_two;
  logic               a;
  logic               b;

  // Edges at the screen borders open up by the margin.
  function automatic logic edge_hit(input logic [15:0] bounds, input logic signed [11:0] x,
                                    input logic [7:0] m);
    logic signed [11:0] left;
    logic signed [11:0] right;
    left  = (bounds[7:0] == EDGE_LEFT_OPEN) ? -$signed({4'd0, m})
                                            : $signed({4'd0, bounds[7:0]});
    right = (bounds[15:8] == EDGE_RIGHT_OPEN) ? $signed(12'd255 + {4'd0, m})
                                              : $signed({4'd0, bounds[15:8]});
    return (x >= left) && (x <= right);
  endfunction

  assign x_ext   = 12'(x_position);
  assign hit_one = edge_hit(cfg.win_one, x_ext, cfg.margin);
  assign hit_two = edge_hit(cfg.win_two, x_ext, cfg.margin);
  assign a       = hit_one ^ cfg.win_control[0];
  assign b       = hit_two ^ cfg.win_control[2];

  always_comb begin
    in_win = 1'b0;
    if (!cfg.win_control[1]) begin
      in_win = cfg.win_control[3] && b;
    end else if (!cfg.win_control[3]) begin
      in_win = a;
    end else begin
      unique case (cwm_comb_t'(cfg.win_control[5:4]))
        COMB_OR:   in_win = a | b;
        COMB_AND:  in_win = a & b;
        COMB_XOR:  in_win = a ^ b;
        COMB_XNOR: in_win = ~(a ^ b);
        default:   in_win = 1'b0;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cwm_blend.sv
`timescale 1ns / 1ps
module cwm_blend (
  input  cwm_pkg::cwm_cfg_t  cfg,
  input  logic               in_win,
  input  logic [3:0]         layer,
  input  logic [14:0]        main_colour,
  input  logic [14:0]        sub_colour,
  input  logic               sub_present,
  output cwm_pkg::cwm_comp_t comp
);
  import cwm_pkg::*;

  logic        clipped;
  logic        math;
  logic        use_sub;
  logic        half;
  logic [14:0] other;

  always_comb begin
    clipped = mode_holds(cwm_win_mode_t'(cfg.math_select[7:6]), in_win);
    math    = !mode_holds(cwm_win_mode_t'(cfg.math_select[5:4]), in_win) &&
              (layer < 4'(LAYER_COUNT)) && cfg.math_enable[layer[2:0]];
    use_sub = math && cfg.math_select[1];
    half    = math && cfg.math_enable[6] && !clipped;
    other   = cfg.fixed_colour;
    if (use_sub) begin
      if (sub_present) begin
        other = sub_colour;
      end else begin
        half = 1'b0;
      end
    end
  end

  // The three components are independent lanes.
  always_comb begin
    logic [4:0] base;
    logic [4:0] operand;
    logic [5:0] acc;
    comp = '0;
    for (int k = 0; k < COMP_COUNT; k++) begin
      base    = clipped ? 5'd0 : main_colour[k*COMP_WIDTH +: COMP_WIDTH];
      operand = other[k*COMP_WIDTH +: COMP_WIDTH];
      acc     = {1'b0, base};
      if (math) begin
        if (cfg.math_enable[7]) begin
          acc = (base >= operand) ? {1'b0, base - operand} : 6'd0;
        end else begin
          acc = {1'b0, base} + {1'b0, operand};
        end
        if (half) begin
          acc = acc >> 1;
        end
        if (acc > {1'b0, COMP_MAX}) begin
          acc = {1'b0, COMP_MAX};
        end
      end
      comp[k] = acc[4:0];
    end
  end

endmodule

FILE: hw/rtl/cwm_scale.sv
`timescale 1ns / 1ps
module cwm_scale (
  input  logic               clk,
  input  logic               en,
  input  cwm_pkg::cwm_comp_t comp,
  input  logic [3:0]         brightness,
  output logic [23:0]        rgb
);
  import cwm_pkg::*;

  logic [COMP_COUNT-1:0][11:0] prod;

  // First stage: expand 5 to 8 bits and multiply by brightness.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < COMP_COUNT; k++) begin
        prod[k] <= {comp[k], comp[k][4:2]} * {8'd0, brightness};
      end
    end
  end

  // Second stage: divide by 15 through the reciprocal; red lands in the top byte.
  always_ff @(posedge clk) begin
    logic [23:0] scaled;
    if (en) begin
      for (int k = 0; k < COMP_COUNT; k++) begin
        scaled = 24'(prod[k]) * RECIP15;
        rgb[(COMP_COUNT-1-k)*8 +: 8] <= scaled[RECIP15_SHIFT +: 8];
      end
    end
  end

endmodule

FILE: hw/rtl/colour_window_math.sv
`timescale 1ns / 1ps
// Colour window math: the last colour stage of the pixel path. A palette-write
// transaction (tuser low) stores one 15-bit colour and returns nothing; it is
// visible to the very next compose transaction. A compose transaction (tuser
// high) returns one 24-bit pixel through the four-stage pipeline: palette
// read and window test, colour math, brightness multiply, divide by 15. A new
// transaction of either kind can be taken in every cycle while the output is
// not stalled. The palette is held in two copies of one RAM so the main and
// sub pixel are read together. A palette entry must be written before a pixel
// uses it; entries at or above PALETTE_ENTRIES read as black and writes to
// them are dropped. Configuration writes are taken at any time but must only
// be made while the pipeline is empty.
module colour_window_math #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // palette_index, palette_colour, main_pixel, sub_pixel, x_position, zero pad
  input  logic [cwm_pkg::TDATA_IN_W-1:0] s_tdata,
  // action
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // rgb
  output logic [cwm_pkg::RGB_W-1:0]      m_tdata,
  input  logic                          cfg_we,
  input  logic [cwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cwm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cwm_pkg::*;

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

  cwm_cfg_t cfg;

  logic              advance;
  logic              accept;
  logic              accept_compose;
  logic              accept_write;
  logic [7:0]        in_index;
  logic [14:0]       in_colour;
  logic [15:0]       in_main;
  logic [15:0]       in_sub;
  logic signed [10:0] in_x;
  logic              in_inside;

  logic              s1_valid;
  logic              s1_inside;
  logic [3:0]        s1_layer;
  logic              s1_main_ok;
  logic              s1_sub_ok;
  logic              s1_sub_present;
  logic [14:0]       ram_main;
  logic [14:0]       ram_sub;
  logic [14:0]       main_colour;
  logic [14:0]       sub_colour;
  cwm_comp_t         blend_comp;

  logic              s2_valid;
  cwm_comp_t         s2_comp;
  logic              s3_valid;

  assign in_index  = s_tdata[7:0];
  assign in_colour = s_tdata[22:8];
  assign in_main   = s_tdata[38:23];
  assign in_sub    = s_tdata[54:39];
  assign in_x      = $signed(s_tdata[65:55]);

  // The whole pipeline moves together; the output register frees the input side.
  assign advance        = !m_tvalid || m_tready;
  assign s_tready       = advance && !rst;
  assign accept         = s_tvalid && s_tready;
  assign accept_compose = accept && (cwm_action_t'(s_tuser) == ACT_COMPOSE);
  assign accept_write   = accept && (cwm_action_t'(s_tuser) == ACT_PAL_WRITE) &&
                          ({1'b0, in_index} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.math_select  <= '0;
      cfg.math_enable  <= '0;
      cfg.fixed_colour <= '0;
      cfg.brightness   <= 4'd15;
      cfg.win_one      <= '0;
      cfg.win_two      <= '0;
      cfg.win_control  <= '0;
      cfg.margin       <= '0;
    end else if (cfg_we) begin
      unique case (cwm_reg_t'(cfg_index))
        REG_MATH_SELECT:  cfg.math_select  <= cfg_data[7:0];
        REG_MATH_ENABLE:  cfg.math_enable  <= cfg_data[7:0];
        REG_FIXED_COLOUR: cfg.fixed_colour <= cfg_data[14:0];
        REG_BRIGHTNESS:   cfg.brightness   <= cfg_data[3:0];
        REG_WIN_ONE:      cfg.win_one      <= cfg_data;
        REG_WIN_TWO:      cfg.win_two      <= cfg_data;
        REG_WIN_CONTROL:  cfg.win_control  <= cfg_data[5:0];
        REG_MARGIN:       cfg.margin       <= cfg_data[7:0];
        default:          cfg.margin       <= cfg.margin;
      endcase
    end
  end

  cwm_window u_window (
    .cfg        (cfg),
    .x_position (in_x),
    .in_win     (in_inside)
  );

  cwm_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_pal_main (
    .clk   (clk),
    .we    (accept_write),
    .waddr (in_index[ADDR_W-1:0]),
    .wdata (in_colour),
    .re    (accept_compose),
    .raddr (in_main[ADDR_W-1:0]),
    .rdata (ram_main)
  );

  cwm_ram #(
    .WIDTH (COLOUR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_pal_sub (
    .clk   (clk),
    .we    (accept_write),
    .waddr (in_index[ADDR_W-1:0]),
    .wdata (in_colour),
    .re    (accept_compose),
    .raddr (in_sub[ADDR_W-1:0]),
    .rdata (ram_sub)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      s1_valid <= accept_compose;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_compose) begin
      s1_inside      <= in_inside;
      s1_layer       <= in_main[11:8];
      s1_main_ok     <= {1'b0, in_main[7:0]} < 9'(PALETTE_ENTRIES);
      s1_sub_ok      <= {1'b0, in_sub[7:0]} < 9'(PALETTE_ENTRIES);
      s1_sub_present <= in_sub[7:0] != 8'd0;
    end
    if (advance) begin
      s2_comp <= blend_comp;
    end
  end

  assign main_colour = s1_main_ok ? ram_main : '0;
  assign sub_colour  = s1_sub_ok ? ram_sub : '0;

  cwm_blend u_blend (
    .cfg         (cfg),
    .in_win      (s1_inside),
    .layer       (s1_layer),
    .main_colour (main_colour),
    .sub_colour  (sub_colour),
    .sub_present (s1_sub_present),
    .comp        (blend_comp)
  );

  cwm_scale u_scale (
    .clk        (clk),
    .en         (advance),
    .comp       (s2_comp),
    .brightness (cfg.brightness),
    .rgb        (m_tdata)
  );

endmodule

FILE: hw/rtl/cwm_checker.sv
`timescale 1ns / 1ps
`include "colour_window_math_macros.svh"
module cwm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cwm_pkg::RGB_W-1:0]       m_tdata
);
  import cwm_pkg::*;

  logic take_write;
  logic take_compose;

  assign take_write   = s_tvalid && s_tready && (cwm_action_t'(s_tuser) == ACT_PAL_WRITE);
  assign take_compose = s_tvalid && s_tready && (cwm_action_t'(s_tuser) == ACT_COMPOSE);

  // A result that waits keeps its value.
  `CWM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // With the output register empty the input side is never held off.
  `CWM_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
  // A palette write leaves a bubble that passes through every stage to the output.
  `CWM_ASSERT_NEXT(a_write_no_result,
                   take_write ##1 m_tready ##1 m_tready ##1 m_tready, !m_tvalid)
  // A compose transaction reaches the output when the output does not stall on the way.
  `CWM_ASSERT_NEXT(a_compose_result,
                   take_compose ##1 m_tready ##1 m_tready ##1 m_tready, m_tvalid)

endmodule

bind colour_window_math cwm_checker u_cwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/sv/tb_colour_window_math.sv
`timescale 1ns / 1ps
module tb_colour_window_math;
  import cwm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 130;
  localparam int RANDOM_PHASES = 11;
  localparam logic [10:0] X_MOST_NEGATIVE = 11'h400;
  localparam logic [10:0] X_MOST_POSITIVE = 11'h3FF;

  typedef struct {
    cwm_action_t        action;
    logic [7:0]         pal_index;
    logic [14:0]        pal_colour;
    logic [15:0]        main_px;
    logic [15:0]        sub_px;
    logic signed [10:0] x_pos;
  } pixel_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // palette_index, palette_colour, main_pixel, sub_pixel, x_position, zero pad
  logic [TDATA_IN_W-1:0] s_tdata = '0;
  // action
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // rgb
  logic [RGB_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_txn_t pending[$];
  pixel_txn_t next_txn;
  logic [RGB_W-1:0] rgb_expected[$];
  logic [RGB_W-1:0] rgb_want;
  logic [COLOUR_W-1:0] palette_shadow [256];
  cwm_cfg_t regs;
  logic [7:0] filled[$];
  bit filled_map [256];
  int src_gap = 0;
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int sink_left = 0;

  colour_window_math dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  // Edges at 0 and 255 open up by the widescreen margin.
  function automatic bit span_hit(logic [15:0] bounds, int x);
    int lo;
    int hi;
    lo = int'(bounds[7:0]);
    hi = int'(bounds[15:8]);
    if (bounds[7:0] == EDGE_LEFT_OPEN) lo = -int'(regs.margin);
    if (bounds[15:8] == EDGE_RIGHT_OPEN) hi = 255 + int'(regs.margin);
    return x >= lo && x <= hi;
  endfunction

  function automatic bit window_hit(int x);
    bit one;
    bit two;
    one = span_hit(regs.win_one, x) ^ regs.win_control[0];
    two = span_hit(regs.win_two, x) ^ regs.win_control[2];
    if (!regs.win_control[1]) return regs.win_control[3] && two;
    if (!regs.win_control[3]) return one;
    case (cwm_comb_t'(regs.win_control[5:4]))
      COMB_OR:  return one | two;
      COMB_AND: return one & two;
      COMB_XOR: return one ^ two;
      default:  return ~(one ^ two);
    endcase
  endfunction

  function automatic bit mode_active(cwm_win_mode_t mode, bit in_win);
    return mode == WIN_ALWAYS || (mode == WIN_OUTSIDE && !in_win) ||
           (mode == WIN_INSIDE && in_win);
  endfunction

  function automatic logic [RGB_W-1:0] predict_rgb(logic [15:0] main_px, logic [15:0] sub_px,
                                                   logic signed [10:0] x_pos);
    logic [14:0] base;
    logic [14:0] other;
    logic [3:0] layer;
    logic [RGB_W-1:0] rgb;
    bit in_win;
    bit clipped;
    bit math;
    bit half;
    int c;
    int s;
    int e;
    in_win = window_hit(int'(x_pos));
    base = palette_shadow[main_px[7:0]];
    layer = main_px[11:8];
    clipped = mode_active(cwm_win_mode_t'(regs.math_select[7:6]), in_win);
    math = !mode_active(cwm_win_mode_t'(regs.math_select[5:4]), in_win) &&
           layer < LAYER_COUNT && regs.math_enable[layer];
    other = regs.fixed_colour;
    half = math && regs.math_enable[6] && !clipped;
    // A missing sub pixel falls back to the fixed colour without halving.
    if (math && regs.math_select[1]) begin
      if (sub_px[7:0] != 8'd0) other = palette_shadow[sub_px[7:0]];
      else half = 1'b0;
    end
    rgb = '0;
    for (int k = 0; k < COMP_COUNT; k++) begin
      c = clipped ? 0 : int'(base[k*COMP_WIDTH +: COMP_WIDTH]);
      if (math) begin
        s = int'(other[k*COMP_WIDTH +: COMP_WIDTH]);
        c = regs.math_enable[7] ? c - s : c + s;
        if (c < 0) c = 0;
        if (half) c = c / 2;
        if (c > int'(COMP_MAX)) c = int'(COMP_MAX);
      end
      e = ((c << 3) | (c >> 2)) * int'(regs.brightness) / 15;
      rgb[16 - 8*k +: 8] = e[7:0];
    end
    return rgb;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_write(logic [7:0] idx, logic [14:0] colour);
    pixel_txn_t t;
    t.action = ACT_PAL_WRITE;
    t.pal_index = idx;
    t.pal_colour = colour;
    t.main_px = 16'($urandom);
    t.sub_px = 16'($urandom);
    t.x_pos = 11'($urandom);
    pending.push_back(t);
    if (!filled_map[idx]) begin
      filled_map[idx] = 1'b1;
      filled.push_back(idx);
    end
  endfunction

  function automatic void queue_compose(logic [15:0] main_px, logic [15:0] sub_px,
                                        logic [10:0] x_pos);
    pixel_txn_t t;
    t.action = ACT_COMPOSE;
    t.pal_index = 8'($urandom);
    t.pal_colour = 15'($urandom);
    t.main_px = main_px;
    t.sub_px = sub_px;
    t.x_pos = x_pos;
    pending.push_back(t);
  endfunction

  // Pixels only ever point at palette entries that have already been written.
  function automatic void queue_random_item();
    logic [15:0] main_px;
    logic [15:0] sub_px;
    logic [10:0] x_pos;
    if ($urandom_range(0, 9) < 3) begin
      queue_write(8'($urandom), 15'($urandom));
    end else begin
      main_px[7:0] = filled[$urandom_range(0, filled.size() - 1)];
      main_px[11:8] = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 5)) : 4'($urandom);
      main_px[15:12] = 4'($urandom);
      sub_px[15:8] = 8'($urandom);
      sub_px[7:0] = ($urandom_range(0, 3) == 0) ? 8'd0 :
                    filled[$urandom_range(0, filled.size() - 1)];
      if ($urandom_range(0, 4) < 3) x_pos = 11'(int'($urandom_range(0, 860)) - 300);
      else x_pos = 11'($urandom);
      queue_compose(main_px, sub_px, x_pos);
    end
  endfunction

  function automatic logic [7:0] pick_edge(logic [7:0] open_val);
    return ($urandom_range(0, 2) == 0) ? open_val : 8'($urandom);
  endfunction

  task automatic write_reg(cwm_reg_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_MATH_SELECT:  regs.math_select = value[7:0];
      REG_MATH_ENABLE:  regs.math_enable = value[7:0];
      REG_FIXED_COLOUR: regs.fixed_colour = value[14:0];
      REG_BRIGHTNESS:   regs.brightness = value[3:0];
      REG_WIN_ONE:      regs.win_one = value;
      REG_WIN_TWO:      regs.win_two = value;
      REG_WIN_CONTROL:  regs.win_control = value[5:0];
      default:          regs.margin = value[7:0];
    endcase
  endtask

  task automatic apply_settings(logic [7:0] sel, logic [7:0] ena, logic [14:0] fixed,
                                logic [3:0] bright, logic [15:0] win1, logic [15:0] win2,
                                logic [5:0] ctl, logic [7:0] margin);
    write_reg(REG_MATH_SELECT, {8'd0, sel});
    write_reg(REG_MATH_ENABLE, {8'd0, ena});
    write_reg(REG_FIXED_COLOUR, {1'b0, fixed});
    write_reg(REG_BRIGHTNESS, {12'd0, bright});
    write_reg(REG_WIN_ONE, win1);
    write_reg(REG_WIN_TWO, win2);
    write_reg(REG_WIN_CONTROL, {10'd0, ctl});
    write_reg(REG_MARGIN, {8'd0, margin});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_settings();
    logic [7:0] sel;
    logic [5:0] ctl;
    sel = 8'($urandom);
    if ($urandom_range(0, 1) == 0) sel[7:6] = WIN_NEVER;
    ctl = 6'($urandom);
    if ($urandom_range(0, 1) == 0) ctl[3:0] = ctl[3:0] | 4'b1010;
    apply_settings(sel, 8'($urandom), 15'($urandom), 4'($urandom_range(1, 15)),
                   {pick_edge(EDGE_RIGHT_OPEN), pick_edge(EDGE_LEFT_OPEN)},
                   {pick_edge(EDGE_RIGHT_OPEN), pick_edge(EDGE_LEFT_OPEN)},
                   ctl, 8'($urandom));
  endtask

  // Writes may still be in the pipeline when the last pixel has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || s_tvalid || rgb_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending.size() > 0) begin
        next_txn = pending.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_txn.action;
        s_tdata <= {6'd0, next_txn.x_pos, next_txn.sub_px, next_txn.main_px,
                    next_txn.pal_colour, next_txn.pal_index};
        if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted transaction updates the palette copy or queues a pixel.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (s_tuser == ACT_PAL_WRITE) palette_shadow[s_tdata[7:0]] = s_tdata[22:8];
      else rgb_expected.push_back(predict_rgb(s_tdata[38:23], s_tdata[54:39],
                                              s_tdata[65:55]));
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      sink_left <= 0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else if (sink_left > 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      sink_left <= $urandom_range(0, 10);
    end else begin
      m_tready <= 1'b1;
      sink_left <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (rgb_expected.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected pixel: rgb %06h", m_tdata);
      end else begin
        rgb_want = rgb_expected.pop_front();
        if (m_tdata !== rgb_want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("rgb mismatch: expected %06h, got %06h", rgb_want, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    regs = '0;
    regs.brightness = 4'd15;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: plain palette lookups at the x extremes.
    queue_write(8'd0, 15'h0000);
    queue_write(8'd255, 15'h7FFF);
    queue_write(8'd1, 15'h001F);
    queue_write(8'd2, 15'h03E0);
    queue_write(8'd3, 15'h7C00);
    queue_write(8'h80, 15'h5555);
    queue_write(8'h7F, 15'h2AAA);
    queue_compose(16'h00FF, 16'h0000, X_MOST_NEGATIVE);
    queue_compose(16'hFF00, 16'hFFFF, X_MOST_POSITIVE);
    queue_compose(16'h5A80, 16'h007F, 11'd0);
    wait_idle();

    // Additive math with halving; only window one enabled; a layer with no math.
    apply_settings(8'h02, 8'h7F, 15'h7FFF, 4'd15, 16'h8010, 16'h0000, 6'h02, 8'd0);
    queue_compose(16'h0003, 16'h0000, 11'd20);
    queue_compose(16'h5501, 16'h0002, 11'd200);
    queue_compose(16'h0601, 16'h0002, 11'd5);
    queue_compose(16'h00FF, 16'h0080, 11'd129);
    wait_idle();

    // Clip to black with subtraction, full margin on open edges, XNOR combine.
    apply_settings(8'hC2, 8'hFF, 15'h1234, 4'd7, 16'hFF00, 16'h30FF, 6'h3A, 8'd255);
    queue_compose(16'h0080, 16'h007F, 11'h701);  // x = -255, on the widened edge
    queue_compose(16'h0201, 16'h0000, 11'h700);  // x = -256, just outside
    queue_compose(16'h3103, 16'h00FF, 11'h1FE);  // x = 510
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        apply_settings(8'hFF, 8'hFF, 15'h7FFF, 4'd15, 16'hFFFF, 16'hFFFF, 6'h3F, 8'hFF);
      else if (p == 1)
        apply_settings(8'h00, 8'h00, 15'h0000, 4'd0, 16'h0000, 16'h0000, 6'h00, 8'h00);
      else
        random_settings();
      if (p == 3) hold_request = 1'b1;
      quiet = (p == RANDOM_PHASES - 1);
      repeat (PHASE_ITEMS) queue_random_item();
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
